// ----- hdl/rotated_two_plane_pixel_plotter_unit_defines.svh -----
// Assertion macros for the two-plane pixel plotter
`ifndef ROTATED_TWO_PLANE_PIXEL_PLOTTER_UNIT_DEFINES_SVH
`define ROTATED_TWO_PLANE_PIXEL_PLOTTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RTPPU_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define RTPPU_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- hdl/rtppu_pkg.sv -----
// Shared types and constants of the two-plane pixel plotter
`timescale 1ns / 1ps
`default_nettype none

package rtppu_pkg;

	localparam int WIDTH_PIXELS_DEF  = 400;
	localparam int HEIGHT_PIXELS_DEF = 300;
	localparam int BUFFER_BYTES_DEF  = 1024;

	localparam int COORD_W = 12;
	localparam int ROW_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 32;

	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
	localparam logic [BYTE_W-1:0] BYTE_MSB  = 8'h80;

	typedef enum logic [1:0] {
		CMD_PLOT   = 2'd0,
		CMD_FILL   = 2'd1,
		CMD_READ   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		COLOR_WHITE = 2'd0,
		COLOR_BLACK = 2'd1,
		COLOR_RED   = 2'd2,
		COLOR_OTHER = 2'd3
	} color_t;

	typedef enum logic {
		REG_ROTATION   = 1'b0,
		REG_PAGE_INDEX = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_MOD,
		ST_FILL
	} state_t;

	typedef struct packed {
		logic [1:0]         rotation;
		logic               page_mode;
		logic signed [31:0] page_base;
	} xl_cfg_t;

	typedef struct packed {
		logic              hit;
		logic [BYTE_W-1:0] bit_mask;
	} plot_info_t;

endpackage

`default_nettype wire

// ----- hdl/rtppu_mem.sv -----
// Black and red bit-plane store, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module rtppu_mem #(
	parameter int DEPTH = rtppu_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               we,
	input  wire logic [$clog2(DEPTH)-1:0]           waddr,
	input  wire logic [rtppu_pkg::BYTE_W-1:0]       wdata_b,
	input  wire logic [rtppu_pkg::BYTE_W-1:0]       wdata_r,
	input  wire logic                               re,
	input  wire logic [$clog2(DEPTH)-1:0]           raddr,
	output logic      [rtppu_pkg::BYTE_W-1:0]       rdata_b,
	output logic      [rtppu_pkg::BYTE_W-1:0]       rdata_r
);
	import rtppu_pkg::*;

	logic [BYTE_W-1:0] black_mem [DEPTH];
	logic [BYTE_W-1:0] red_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			black_mem[waddr] <= wdata_b;
			red_mem[waddr]   <= wdata_r;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_b <= black_mem[raddr];
			rdata_r <= red_mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/rtppu_xlate.sv -----
// Coordinate clip, rotation, page offset and byte index pipeline
`timescale 1ns / 1ps
`default_nettype none

module rtppu_xlate #(
	parameter int WIDTH_PIXELS  = rtppu_pkg::WIDTH_PIXELS_DEF,
	parameter int HEIGHT_PIXELS = rtppu_pkg::HEIGHT_PIXELS_DEF,
	parameter int BUFFER_BYTES  = rtppu_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              load,
	input  wire rtppu_pkg::xl_cfg_t                cfg,
	input  wire logic signed [15:0]                pos_x,
	input  wire logic signed [15:0]                pos_y,
	output logic [$clog2(BUFFER_BYTES)-1:0]        rd_addr,
	output logic [$clog2(BUFFER_BYTES)-1:0]        addr_s2,
	output rtppu_pkg::plot_info_t                  info_s2
);
	import rtppu_pkg::*;

	localparam int AddrW    = $clog2(BUFFER_BYTES);
	localparam int RowBytes = WIDTH_PIXELS / 8;
	localparam int PageRows = BUFFER_BYTES / RowBytes;
	localparam logic [COORD_W-1:0] XMax = COORD_W'(WIDTH_PIXELS - 1);
	localparam logic [COORD_W-1:0] YMax = COORD_W'(HEIGHT_PIXELS - 1);

	logic [15:0]          lim_x;
	logic [15:0]          lim_y;
	logic                 on_screen;
	logic [COORD_W-1:0]   x_c;
	logic [COORD_W-1:0]   y_c;
	logic [COORD_W-1:0]   px;
	logic [COORD_W-1:0]   py;
	logic signed [31:0]   py_rel;
	logic                 in_page;

	logic [COORD_W-1:0]   px_s1;
	logic [ROW_W-1:0]     py_s1;
	logic                 hit_s1;

	logic [IDX_W-1:0]     idx;
	logic                 in_store;

	always_comb begin
		lim_x     = cfg.rotation[0] ? 16'(HEIGHT_PIXELS) : 16'(WIDTH_PIXELS);
		lim_y     = cfg.rotation[0] ? 16'(WIDTH_PIXELS) : 16'(HEIGHT_PIXELS);
		on_screen = !pos_x[15] && !pos_y[15] &&
			(unsigned'(pos_x) < lim_x) && (unsigned'(pos_y) < lim_y);
		x_c = pos_x[COORD_W-1:0];
		y_c = pos_y[COORD_W-1:0];
		case (cfg.rotation)
			2'd1: begin
				px = XMax - y_c;
				py = x_c;
			end
			2'd2: begin
				px = XMax - x_c;
				py = YMax - y_c;
			end
			2'd3: begin
				px = y_c;
				py = YMax - x_c;
			end
			default: begin
				px = x_c;
				py = y_c;
			end
		endcase
		py_rel  = $signed(32'(py)) - cfg.page_base;
		in_page = !cfg.page_mode ||
			(!py_rel[31] && (unsigned'(py_rel) < 32'(PageRows)));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_s1  <= px;
			py_s1  <= ROW_W'(unsigned'(py_rel));
			hit_s1 <= on_screen && in_page;
		end
	end

	always_comb begin
		idx      = 32'(px_s1[COORD_W-1:3]) + 32'(py_s1) * 32'(RowBytes);
		in_store = idx < 32'(BUFFER_BYTES);
		rd_addr  = AddrW'(idx);
	end

	always_ff @(posedge clk) begin
		addr_s2          <= rd_addr;
		info_s2.hit      <= hit_s1 && in_store;
		info_s2.bit_mask <= BYTE_MSB >> px_s1[2:0];
	end

endmodule

`default_nettype wire

// ----- hdl/rotated_two_plane_pixel_plotter_unit.sv -----
// Top level of the rotated two-plane pixel plotter
//
// Input channel: in_valid/in_stall with command, pos_x, pos_y, color_code,
// read_index, read_plane; a beat moves when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall with read_data and written, one beat
// per input beat, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 rotation, 1 page
// index) and cfg_data; cfg_ready is always high.
// Items are taken one at a time. From the accepting edge a plot or read
// passes through the byte index and memory read, then the write-back, and
// then the output register, which gives the result beat. A fill sweeps the
// store one byte of each plane per cycle. A new item is taken only once the
// last has left its write-back or sweep, which waits while out_stall holds.
// After reset both planes are cleared by a sweep over the whole store,
// during which in_stall is high; configuration writes are taken meanwhile.
// The result sits in an output register, so the next item is accepted while
// it waits; an item whose result is ready holds while out_stall is high.
`timescale 1ns / 1ps
`default_nettype none

`include "rotated_two_plane_pixel_plotter_unit_defines.svh"

module rotated_two_plane_pixel_plotter_unit #(
	parameter int WIDTH_PIXELS  = rtppu_pkg::WIDTH_PIXELS_DEF,
	parameter int HEIGHT_PIXELS = rtppu_pkg::HEIGHT_PIXELS_DEF,
	parameter int BUFFER_BYTES  = rtppu_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         command,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic [1:0]         color_code,
	input  wire logic [9:0]         read_index,
	input  wire logic               read_plane,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              read_data,
	output logic                    written,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [6:0]         cfg_data
);
	import rtppu_pkg::*;

	localparam int AddrW    = $clog2(BUFFER_BYTES);
	localparam int RowBytes = WIDTH_PIXELS / 8;
	localparam int PageRows = BUFFER_BYTES / RowBytes;
	localparam logic [AddrW-1:0] SweepLast = AddrW'(BUFFER_BYTES - 1);

	state_t             state_q;
	state_t             state_nx;
	logic [AddrW-1:0]   sweep_q;
	logic               sweep_last;
	xl_cfg_t            cfg_q;

	cmd_t               cmd_q;
	color_t             color_q;
	logic               plane_q;
	logic [AddrW-1:0]   rd_addr_q;
	logic               rd_ok_q;
	logic [BYTE_W-1:0]  fill_b_q;
	logic [BYTE_W-1:0]  fill_r_q;

	logic               in_acc;
	logic               out_free;
	cmd_t               cmd_in;

	logic               mem_we;
	logic [AddrW-1:0]   mem_waddr;
	logic [BYTE_W-1:0]  mem_wdata_b;
	logic [BYTE_W-1:0]  mem_wdata_r;
	logic               mem_re;
	logic [AddrW-1:0]   mem_raddr;
	logic [BYTE_W-1:0]  mem_rdata_b;
	logic [BYTE_W-1:0]  mem_rdata_r;

	logic [AddrW-1:0]   xl_rd_addr;
	logic [AddrW-1:0]   xl_addr_s2;
	plot_info_t         xl_info_s2;

	logic               res_load;
	logic [BYTE_W-1:0]  res_data;
	logic               res_wr;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  read_data_q;
	logic               written_q;

	assign cfg_ready  = 1'b1;
	assign cmd_in     = cmd_t'(command);
	assign in_acc     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign sweep_last = (sweep_q == SweepLast);
	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign written    = written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation  <= 2'd0;
			cfg_q.page_mode <= 1'b0;
			cfg_q.page_base <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROTATION: cfg_q.rotation <= cfg_data[1:0];
				REG_PAGE_INDEX: begin
					cfg_q.page_mode <= !cfg_data[6] && (cfg_data != 7'd0);
					cfg_q.page_base <= (!cfg_data[6] && (cfg_data != 7'd0)) ?
						$signed(32'(cfg_data[5:0]) * 32'(PageRows)) : '0;
				end
				default: cfg_q.rotation <= cfg_q.rotation;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q     <= cmd_in;
			color_q   <= color_t'(color_code);
			plane_q   <= read_plane;
			rd_addr_q <= AddrW'(read_index);
			rd_ok_q   <= 32'(read_index) < 32'(BUFFER_BYTES);
			fill_b_q  <= (color_t'(color_code) == COLOR_BLACK) ? BYTE_ONES : '0;
			fill_r_q  <= (color_t'(color_code) == COLOR_RED) ? BYTE_ONES : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE) begin
				sweep_q <= '0;
			end else if ((state_q == ST_CLEAR || state_q == ST_FILL) && !sweep_last) begin
				sweep_q <= sweep_q + AddrW'(1);
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: if (sweep_last) state_nx = ST_IDLE;
			ST_IDLE: begin
				if (in_acc) state_nx = (cmd_in == CMD_FILL) ? ST_FILL : ST_ADDR;
			end
			ST_ADDR: state_nx = ST_MOD;
			ST_MOD: if (out_free) state_nx = ST_IDLE;
			ST_FILL: if (sweep_last && out_free) state_nx = ST_IDLE;
			default: state_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		mem_we      = 1'b0;
		mem_waddr   = sweep_q;
		mem_wdata_b = '0;
		mem_wdata_r = '0;
		mem_re      = 1'b0;
		mem_raddr   = (cmd_q == CMD_READ) ? rd_addr_q : xl_rd_addr;
		res_load    = 1'b0;
		res_data    = '0;
		res_wr      = 1'b0;
		unique case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_IDLE: in_stall = 1'b0;
			ST_ADDR: mem_re = 1'b1;
			ST_MOD: begin
				mem_we      = (cmd_q == CMD_PLOT) && xl_info_s2.hit;
				mem_waddr   = xl_addr_s2;
				mem_wdata_b = (mem_rdata_b & ~xl_info_s2.bit_mask) |
					((color_q == COLOR_BLACK) ? xl_info_s2.bit_mask : '0);
				mem_wdata_r = (mem_rdata_r & ~xl_info_s2.bit_mask) |
					((color_q == COLOR_RED) ? xl_info_s2.bit_mask : '0);
				res_load    = out_free;
				res_wr      = (cmd_q == CMD_PLOT) && xl_info_s2.hit;
				if (cmd_q == CMD_READ && rd_ok_q) begin
					res_data = plane_q ? mem_rdata_r : mem_rdata_b;
				end
			end
			ST_FILL: begin
				mem_we      = 1'b1;
				mem_wdata_b = fill_b_q;
				mem_wdata_r = fill_r_q;
				res_load    = sweep_last && out_free;
				res_wr      = 1'b1;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			read_data_q <= res_data;
			written_q   <= res_wr;
		end
	end

	rtppu_xlate #(
		.WIDTH_PIXELS  (WIDTH_PIXELS),
		.HEIGHT_PIXELS (HEIGHT_PIXELS),
		.BUFFER_BYTES  (BUFFER_BYTES)
	) u_xlate (
		.clk     (clk),
		.load    (in_acc),
		.cfg     (cfg_q),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.rd_addr (xl_rd_addr),
		.addr_s2 (xl_addr_s2),
		.info_s2 (xl_info_s2)
	);

	rtppu_mem #(
		.DEPTH (BUFFER_BYTES)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata_b (mem_wdata_b),
		.wdata_r (mem_wdata_r),
		.re      (mem_re),
		.raddr   (mem_raddr),
		.rdata_b (mem_rdata_b),
		.rdata_r (mem_rdata_r)
	);

	`RTPPU_ASSERT_NOW(a_no_write_idle, state_q == ST_IDLE, !mem_we, "store written while idle")
	`RTPPU_ASSERT_NOW(a_mod_write_plot, mem_we && state_q == ST_MOD, cmd_q == CMD_PLOT, "write-back for a non-plot item")
	`RTPPU_ASSERT_NEXT(a_fill_enters_sweep, in_acc && cmd_in == CMD_FILL, state_q == ST_FILL, "fill did not start its sweep")
	`RTPPU_ASSERT_NOW(a_result_source, $rose(out_valid_q), $past(state_q) == ST_MOD || $past(state_q) == ST_FILL, "result beat from a state that produces none")

endmodule

`default_nettype wire
